// ===== hdl/sce_pkg.sv =====
// sce_pkg: shared codes, fixed field widths and control types for the spline evaluator.
// No dependencies; used by sce_req_if, sce_point_store, sce_axis_path and the top level.
package sce_pkg;

   // Fixed field widths
   localparam int INDEX_BITS     = 6;
   localparam int COUNT_BITS     = 7;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;

   // Control point table depth, tied to the index and count widths
   localparam int MAX_POINTS     = 64;

   // Item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Curve modes
   localparam logic MODE_LINEAR  = 1'b0;
   localparam logic MODE_CATMULL = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_MODE  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POINT_COUNT = 1'b1;

   // Register reset values
   localparam logic                  MODE_RESET  = MODE_CATMULL;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd2;

   // Segment control that travels with an evaluate beat
   typedef struct packed {
      logic                  mode;
      logic                  first;
      logic                  last;
      logic [COUNT_BITS-1:0] segs;
   } axis_ctrl_type;

endpackage

// ===== hdl/sce_req_if.sv =====
// sce_req_if: request channel (valid/ready plus write or evaluate payload).
// Depends on sce_pkg.
interface sce_req_if #(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
);
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [sce_pkg::INDEX_BITS-1:0]    point_index;
   logic signed [COORD_BITS-1:0]      point_x;
   logic signed [COORD_BITS-1:0]      point_y;
   logic [T_FRAC_BITS:0]              t_param;

   modport source (output valid, op, point_index, point_x, point_y, t_param, input ready);
   modport sink   (input valid, op, point_index, point_x, point_y, t_param, output ready);
endinterface

// ===== hdl/sce_rsp_if.sv =====
// sce_rsp_if: result channel (valid/ready plus position and scaled tangent).
// No dependencies.
interface sce_rsp_if #(
   parameter int COORD_BITS = 32
);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_BITS-1:0]   pos_x;
   logic signed [COORD_BITS-1:0]   pos_y;
   logic signed [COORD_BITS+7:0]   tan_x;
   logic signed [COORD_BITS+7:0]   tan_y;

   modport source (output valid, pos_x, pos_y, tan_x, tan_y, input ready);
   modport sink   (input valid, pos_x, pos_y, tan_x, tan_y, output ready);
endinterface

// ===== hdl/sce_point_store.sv =====
// sce_point_store: control point memory in four banks (index mod 4), one write port
// and one registered read per bank per cycle. Depends on sce_pkg.
module sce_point_store #(
   parameter int COORD_BITS = 32,
   parameter int BANK_DEPTH = (sce_pkg::MAX_POINTS + 3) / 4,
   parameter int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [3:0][BANK_AW-1:0]              rd_addr,
   output logic [3:0][2*COORD_BITS-1:0]         rd_data,
   input  logic                                 wr_en,
   input  logic [sce_pkg::INDEX_BITS-1:0]       wr_index,
   input  logic [2*COORD_BITS-1:0]              wr_data
);

   logic [BANK_AW-1:0] wr_addr;
   logic [1:0]         wr_bank;
   logic               wr_ok;

   // Bank select and row address; indexes past the table are dropped
   assign wr_bank = wr_index[1:0];
   assign wr_addr = BANK_AW'(wr_index >> 2);
   assign wr_ok   = 32'(wr_index) < sce_pkg::MAX_POINTS;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [2*COORD_BITS-1:0] mem [BANK_DEPTH];
      logic [2*COORD_BITS-1:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr_en && wr_ok && wr_bank == 2'(b)) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            q_ff <= mem[rd_addr[b]];
         end
      end

      assign rd_data[b] = q_ff;
   end

endmodule

// ===== hdl/sce_axis_path.sv =====
// sce_axis_path: six-stage fixed-point datapath for one coordinate axis:
// coefficients, three Horner steps with rounded products, tangent scale, saturation.
// Depends on sce_pkg.
module sce_axis_path #(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           en,
   input  sce_pkg::axis_ctrl_type         ctl,
   input  logic [T_FRAC_BITS:0]           lt,
   input  logic signed [COORD_BITS-1:0]   p0,
   input  logic signed [COORD_BITS-1:0]   p1,
   input  logic signed [COORD_BITS-1:0]   p2,
   input  logic signed [COORD_BITS-1:0]   p3,
   output logic signed [COORD_BITS-1:0]   pos,
   output logic signed [COORD_BITS+7:0]   tan
);

   localparam int W    = COORD_BITS + 8;
   localparam int TB   = COORD_BITS + 8;
   localparam int PW   = W + sce_pkg::COUNT_BITS;
   localparam int MW   = W + T_FRAC_BITS + 1;
   localparam logic [MW-1:0] HALF = MW'(1) << (T_FRAC_BITS - 1);
   localparam logic [W-1:0]  PLIM = W'(1) << (COORD_BITS - 1);
   localparam logic [PW-1:0] TLIM = PW'(1) << (TB - 1);

   // round(a * l / 2^T), ties away from zero, on sign and magnitude
   function automatic logic signed [W-1:0] mulr(input logic signed [W-1:0] a,
                                                input logic [T_FRAC_BITS:0] l);
      logic [W-1:0]  m;
      logic [MW-1:0] p;
      logic [W-1:0]  q;
      m = a[W-1] ? W'(-a) : W'(a);
      p = MW'(m) * MW'(l) + HALF;
      q = W'(p >> T_FRAC_BITS);
      return a[W-1] ? -$signed(q) : $signed(q);
   endfunction

   // Stage 1: end extrapolation and polynomial coefficients
   logic signed [W-1:0] q0, q1, q2, q3, e0, e3;
   logic signed [W-1:0] a_in, b_in, c_in, d_in;
   logic signed [W-1:0] a1_ff, b1_ff, c1_ff, d1_ff;
   logic [T_FRAC_BITS:0] l1_ff;
   sce_pkg::axis_ctrl_type ctl1_ff;

   always_comb begin
      q0 = W'(p0);
      q1 = W'(p1);
      q2 = W'(p2);
      q3 = W'(p3);
      e0 = ctl.first ? (q1 <<< 1) - q2 : q0;
      e3 = ctl.last  ? (q2 <<< 1) - q1 : q3;
      if (ctl.mode == sce_pkg::MODE_CATMULL) begin
         a_in = q1 <<< 1;
         b_in = q2 - e0;
         c_in = (e0 <<< 1) - ((q1 <<< 2) + q1) + (q2 <<< 2) - e3;
         d_in = e3 - e0 + ((q1 <<< 1) + q1) - ((q2 <<< 1) + q2);
      end else begin
         a_in = q1;
         b_in = q2 - q1;
         c_in = '0;
         d_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= a_in;
         b1_ff   <= b_in;
         c1_ff   <= c_in;
         d1_ff   <= d_in;
         l1_ff   <= lt;
         ctl1_ff <= ctl;
      end
   end

   // Stage 2: first products, d*u and 3d*u
   logic signed [W-1:0] u2_ff, v2_ff, a2_ff, b2_ff, c2_ff;
   logic [T_FRAC_BITS:0] l2_ff;
   sce_pkg::axis_ctrl_type ctl2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         u2_ff   <= mulr(d1_ff, l1_ff);
         v2_ff   <= mulr((d1_ff <<< 1) + d1_ff, l1_ff);
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         c2_ff   <= c1_ff;
         l2_ff   <= l1_ff;
         ctl2_ff <= ctl1_ff;
      end
   end

   // Stage 3: second Horner step for position and tangent
   logic signed [W-1:0] u3_ff, v3_ff, a3_ff, b3_ff;
   logic [T_FRAC_BITS:0] l3_ff;
   sce_pkg::axis_ctrl_type ctl3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         u3_ff   <= mulr(u2_ff + c2_ff, l2_ff);
         v3_ff   <= mulr(v2_ff + (c2_ff <<< 1), l2_ff);
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         l3_ff   <= l2_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   // Stage 4: last position product, tangent sum
   logic signed [W-1:0] u4_ff, tac4_ff, a4_ff;
   sce_pkg::axis_ctrl_type ctl4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         u4_ff   <= mulr(u3_ff + b3_ff, l3_ff);
         tac4_ff <= v3_ff + b3_ff;
         a4_ff   <= a3_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   // Stage 5: position sum, tangent magnitude times segment count
   logic signed [W-1:0] acc5_ff;
   logic [W-1:0]        tabs;
   logic [PW-1:0]       tmag5_ff;
   logic                tneg5_ff;
   logic                mode5_ff;

   assign tabs = tac4_ff[W-1] ? W'(-tac4_ff) : W'(tac4_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         acc5_ff  <= u4_ff + a4_ff;
         tmag5_ff <= PW'(tabs) * PW'(ctl4_ff.segs);
         tneg5_ff <= tac4_ff[W-1];
         mode5_ff <= ctl4_ff.mode;
      end
   end

   // Stage 6: halving (cubic mode) and saturation into the output register
   logic [W-1:0]            pmag, ph;
   logic [PW-1:0]           th;
   logic signed [COORD_BITS-1:0] pos_in;
   logic signed [TB-1:0]    tan_in;
   logic signed [COORD_BITS-1:0] pos_ff;
   logic signed [TB-1:0]    tan_ff;

   always_comb begin
      pmag = acc5_ff[W-1] ? W'(-acc5_ff) : W'(acc5_ff);
      ph   = (mode5_ff == sce_pkg::MODE_CATMULL) ? (pmag + W'(1)) >> 1 : pmag;
      th   = (mode5_ff == sce_pkg::MODE_CATMULL) ? (tmag5_ff + PW'(1)) >> 1 : tmag5_ff;
      if (acc5_ff[W-1]) begin
         pos_in = (ph >= PLIM) ? -$signed(COORD_BITS'(PLIM)) : -$signed(COORD_BITS'(ph));
      end else begin
         pos_in = (ph >= PLIM) ? $signed(COORD_BITS'(PLIM - W'(1))) : $signed(COORD_BITS'(ph));
      end
      if (tneg5_ff) begin
         tan_in = (th >= TLIM) ? -$signed(TB'(TLIM)) : -$signed(TB'(th));
      end else begin
         tan_in = (th >= TLIM) ? $signed(TB'(TLIM - PW'(1))) : $signed(TB'(th));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_in;
         tan_ff <= tan_in;
      end
   end

   assign pos = pos_ff;
   assign tan = tan_ff;

endmodule

// ===== hdl/spline_curve_evaluator_unit.sv =====
// spline_curve_evaluator_unit: top level; segment lookup, banked point reads,
// two axis pipelines and the result register. Depends on sce_pkg, the channel
// interfaces, sce_point_store and sce_axis_path.
//
//   channel   direction  handshake           payload
//   req_chan  in         valid/ready         op, point_index, point_x, point_y, t_param
//   rsp_chan  out        valid/ready         pos_x, pos_y, tan_x, tan_y
//   csr_*     in         csr_wr_en only      csr_index, csr_wr_data
//
// One beat is taken per cycle, writes and evaluates alike, while no held result stalls the pipeline.
// An evaluate result is registered through the banked point read, taken at the beat edge,
// and then six axis stages (three rounded products in series) before it is valid.
// Writes produce no result and land in the point store at their beat.
// A held result stalls the whole pipeline and drops req ready until taken.
// Synchronous reset clears the pipeline valids and the configuration registers; points are not cleared.
module spline_curve_evaluator_unit #(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   sce_req_if.sink                                req_chan,
   sce_rsp_if.source                              rsp_chan,
   input  logic                                   csr_wr_en,
   input  logic [sce_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sce_pkg::CSR_DATA_BITS-1:0]      csr_wr_data
);

   localparam int CB         = sce_pkg::COUNT_BITS;
   localparam int IW         = CB + 1;
   localparam int SW         = T_FRAC_BITS + 1 + CB;
   localparam int BANK_DEPTH = (sce_pkg::MAX_POINTS + 3) / 4;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int DEPTH      = 7;
   localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS + 1)'(1) << T_FRAC_BITS;

   // Configuration registers
   logic          mode_ff;
   logic [CB-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sce_pkg::MODE_RESET;
         count_ff <= sce_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sce_pkg::CSR_CURVE_MODE:  mode_ff  <= csr_wr_data[0];
            sce_pkg::CSR_POINT_COUNT: count_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Pipeline enable and accept
   logic [DEPTH-1:0] vld_ff;
   logic             en, accept, accept_eval, accept_write;

   assign en           = !vld_ff[DEPTH-1] || rsp_chan.ready;
   assign accept       = req_chan.valid && en;
   assign accept_eval  = accept && req_chan.op == sce_pkg::OP_EVAL;
   assign accept_write = accept && req_chan.op == sce_pkg::OP_WRITE;
   assign req_chan.ready = en;

   // Segment lookup: clamp count and t, seg = floor(t*segs), local t
   logic [CB-1:0]          n, segs, seg_raw, seg;
   logic [T_FRAC_BITS:0]   tc, lt;
   logic [SW-1:0]          scaled;
   logic [IW-1:0]          base;
   logic [1:0]             boff;
   logic [3:0][BANK_AW-1:0] rd_addr;
   sce_pkg::axis_ctrl_type ctl_in;

   always_comb begin
      if (count_ff < CB'(2)) begin
         n = CB'(2);
      end else if (32'(count_ff) > sce_pkg::MAX_POINTS) begin
         n = CB'(sce_pkg::MAX_POINTS);
      end else begin
         n = count_ff;
      end
      segs    = n - CB'(1);
      tc      = (req_chan.t_param > T_ONE) ? T_ONE : req_chan.t_param;
      scaled  = SW'(tc) * SW'(segs);
      seg_raw = CB'(scaled >> T_FRAC_BITS);
      if (seg_raw >= segs) begin
         seg = segs - CB'(1);
         lt  = T_ONE;
      end else begin
         seg = seg_raw;
         lt  = {1'b0, scaled[T_FRAC_BITS-1:0]};
      end
      ctl_in.mode  = mode_ff;
      ctl_in.first = seg == '0;
      ctl_in.last  = (IW'(seg) + IW'(2)) >= IW'(n);
      ctl_in.segs  = segs;
      // points seg-1 .. seg+2 fall in four different banks
      base = IW'(seg) - IW'(1);
      for (int b = 0; b < 4; b++) begin
         // offset of bank b from base, modulo 4
         boff       = 2'(b) - base[1:0];
         rd_addr[b] = BANK_AW'((base + IW'(boff)) >> 2);
      end
   end

   // Point store: write at the write beat, read at the evaluate beat
   logic [3:0][2*COORD_BITS-1:0] rd_data;

   sce_point_store #(
      .COORD_BITS (COORD_BITS),
      .BANK_DEPTH (BANK_DEPTH),
      .BANK_AW    (BANK_AW)
   ) u_store (
      .clock    (clock),
      .rd_en    (en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (accept_write),
      .wr_index (req_chan.point_index),
      .wr_data  ({req_chan.point_x, req_chan.point_y})
   );

   // Stage 0 control, aligned with the read data
   sce_pkg::axis_ctrl_type ctl0_ff;
   logic [T_FRAC_BITS:0]   lt0_ff;
   logic [1:0]             base0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ctl0_ff  <= ctl_in;
         lt0_ff   <= lt;
         base0_ff <= base[1:0];
      end
   end

   // Valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], accept_eval};
      end
   end

   // Rotate banks back into point order p0..p3
   logic [3:0][2*COORD_BITS-1:0] pt;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pt[k] = rd_data[2'(base0_ff + 2'(k))];
      end
   end

   sce_axis_path #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_axis_x (
      .clock (clock),
      .en    (en),
      .ctl   (ctl0_ff),
      .lt    (lt0_ff),
      .p0    ($signed(pt[0][2*COORD_BITS-1:COORD_BITS])),
      .p1    ($signed(pt[1][2*COORD_BITS-1:COORD_BITS])),
      .p2    ($signed(pt[2][2*COORD_BITS-1:COORD_BITS])),
      .p3    ($signed(pt[3][2*COORD_BITS-1:COORD_BITS])),
      .pos   (rsp_chan.pos_x),
      .tan   (rsp_chan.tan_x)
   );

   sce_axis_path #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_axis_y (
      .clock (clock),
      .en    (en),
      .ctl   (ctl0_ff),
      .lt    (lt0_ff),
      .p0    ($signed(pt[0][COORD_BITS-1:0])),
      .p1    ($signed(pt[1][COORD_BITS-1:0])),
      .p2    ($signed(pt[2][COORD_BITS-1:0])),
      .p3    ($signed(pt[3][COORD_BITS-1:0])),
      .pos   (rsp_chan.pos_y),
      .tan   (rsp_chan.tan_y)
   );

   assign rsp_chan.valid = vld_ff[DEPTH-1];

endmodule

// ===== hdl/sce_checker.sv =====
// sce_checker: port-level assertions for spline_curve_evaluator_unit, with its bind.
// Depends on the top level's channel interfaces.
module sce_checker #(
   parameter int COORD_BITS = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_BITS-1:0]  pos_x,
   input logic signed [COORD_BITS-1:0]  pos_y,
   input logic signed [COORD_BITS+7:0]  tan_x,
   input logic signed [COORD_BITS+7:0]  tan_y
);

   // A held result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input side takes beats only when the result register can move
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req ready does not track the result register");

   // A held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(pos_x) && $stable(pos_y) && $stable(tan_x) && $stable(tan_y))
      else $error("result payload changed while stalled");

endmodule

bind spline_curve_evaluator_unit sce_checker #(
   .COORD_BITS (COORD_BITS)
) u_sce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pos_x     (rsp_chan.pos_x),
   .pos_y     (rsp_chan.pos_y),
   .tan_x     (rsp_chan.tan_x),
   .tan_y     (rsp_chan.tan_y)
);
